### sv/pla_pkg.sv
package pla_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    // Fixed widths of the result fields.
    localparam int LEN_BITS = 25;
    localparam int IDX_BITS = 8;
    localparam int CNT_BITS = 9;
    localparam int RES_BITS = 2 * LEN_BITS + IDX_BITS + CNT_BITS;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DIFF   = 9'b000000010,
        ST_SQX    = 9'b000000100,
        ST_SQY    = 9'b000001000,
        ST_SUMSQ  = 9'b000010000,
        ST_ROOT   = 9'b000100000,
        ST_ACC    = 9'b001000000,
        ST_UPDATE = 9'b010000000,
        ST_FINISH = 9'b100000000
    } pla_state_t;

    // Handshake between the sequencer and the square-root unit.
    typedef struct packed {
        logic start;
    } pla_sqrt_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pla_sqrt_sts_t;

endpackage

### sv/pla_sqrt_unit.sv
module pla_sqrt_unit
    import pla_pkg::*;
#(
    parameter int ROOT_W = COORD_BITS_DEF + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pla_sqrt_req_t         req,
    input  logic [2*ROOT_W-1:0]   radicand,
    output pla_sqrt_sts_t         sts,
    output logic [ROOT_W-1:0]     root
);

    // Restoring square root, one result bit (two radicand bits) per cycle.
    localparam int RAD_W = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [ROOT_W+1:0] rem_shift;
    logic [ROOT_W+1:0] trial;

    always_comb begin
        rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};

        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = root_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg && !done_reg)
        else $error("square root started while busy");

    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("square root done while still stepping");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= LAST_STEP)
        else $error("square root step count out of range");

endmodule

### sv/polyline_length_accumulator.sv
// A point with a segment holds s_axis_tready low from its acceptance through DIFF, SQX, SQY,
// SUMSQ, ROOT, ACC, UPDATE and FINISH, so the next point waits until it is through; ROOT runs
// the bit-serial square root of COORD_BITS + 1 steps. The first point of a polyline frees the
// input after UPDATE and FINISH, a point beyond capacity after FINISH alone.
// A result is valid on m_axis from the edge that frees the input, later if one still waits.
// Reset (aresetn low, synchronous) clears the polyline state and drops any held result.
module polyline_length_accumulator
    import pla_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // Fields from bit 0 up: x_coord, y_coord, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // Fields from bit 0 up: total_length, head_offset, head_index, point_count, zero fill.
    output logic [M_TDATA_W-1:0]                   m_axis_tdata,
    // Fields: overflowed.
    output logic                                   m_axis_tuser
);

    // Width plan. A coordinate difference fits COORD_BITS unsigned bits, its
    // square 2*COORD_BITS bits, and the sum of two squares one bit more, so
    // the root needs COORD_BITS+1 bits and COORD_BITS+1 steps.
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int HP_W   = $clog2(MAX_POINTS);
    localparam int SUM_W  = ((LEN_BITS > ROOT_W) ? LEN_BITS : ROOT_W) + 1;
    localparam int PAD_W  = M_TDATA_W - RES_BITS;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);

    // Sequencer state.
    pla_state_t state_reg, state_next;

    // Captured request.
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic                         last_reg, last_next;

    // Polyline state.
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [LEN_BITS-1:0]          length_reg, length_next;
    logic [LEN_BITS-1:0]          head_sum_reg, head_sum_next;
    logic [HP_W-1:0]              head_pos_reg, head_pos_next;
    logic                         dropped_reg, dropped_next;

    // Segment datapath.
    logic [COORD_BITS-1:0] ax_reg, ax_next;
    logic [COORD_BITS-1:0] ay_reg, ay_next;
    logic [SQ_W-1:0]       prod_reg, prod_next;
    logic [SQ_W-1:0]       sumsq_reg, sumsq_next;

    // Output register; it lets the sequencer move on while a result waits.
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      mul_op;
    logic [SQ_W-1:0]            mul_out;
    logic [SUM_W-1:0]           acc_sum;
    logic [2*ROOT_W-1:0]        radicand;
    logic [ROOT_W-1:0]          seg_root;
    logic [CNT_W+CNT_BITS-1:0]  count_ext;
    logic [HP_W+IDX_BITS-1:0]   head_pos_ext;
    logic                       accept;
    logic                       out_free;

    pla_sqrt_req_t sqrt_req;
    pla_sqrt_sts_t sqrt_sts;

    pla_sqrt_unit #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (sqrt_req),
        .radicand (radicand),
        .sts      (sqrt_sts),
        .root     (seg_root)
    );

    // The block takes one point at a time and only while the sequencer is idle.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // The single multiplier squares dx in one state and dy in the next.
    assign mul_op  = (state_reg == ST_SQX) ? ax_reg : ay_reg;
    assign mul_out = mul_op * mul_op;

    // The sum of squares goes straight into the root unit as it starts.
    assign sqrt_req.start = (state_reg == ST_SUMSQ);
    assign radicand = (2*ROOT_W)'(sumsq_reg) + (2*ROOT_W)'(prod_reg);

    assign dx = {x_reg[COORD_BITS-1], x_reg} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign dy = {y_reg[COORD_BITS-1], y_reg} - {prev_y_reg[COORD_BITS-1], prev_y_reg};

    // Saturating add of the new segment onto the running length.
    assign acc_sum = SUM_W'(length_reg) + SUM_W'(seg_root);

    // Counts are reported through their low bits, zero-extended when narrower.
    assign count_ext    = {{CNT_BITS{1'b0}}, count_reg};
    assign head_pos_ext = {{IDX_BITS{1'b0}}, head_pos_reg};

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        last_next     = last_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        head_sum_next = head_sum_reg;
        head_pos_next = head_pos_reg;
        dropped_next  = dropped_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        prod_next     = prod_reg;
        sumsq_next    = sumsq_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x_next    = s_axis_tdata[COORD_BITS-1:0];
                    y_next    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                    last_next = s_axis_tlast;
                    // A full polyline ignores the point but still honors its end mark.
                    if (count_reg == CNT_FULL) begin
                        dropped_next = 1'b1;
                        state_next   = ST_FINISH;
                    end else if (count_reg == '0) begin
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                ax_next    = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
                ay_next    = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
                state_next = ST_SQX;
            end
            ST_SQX: begin
                prod_next  = mul_out;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                sumsq_next = prod_reg;
                prod_next  = mul_out;
                state_next = ST_SUMSQ;
            end
            ST_SUMSQ: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_sts.done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (acc_sum > SUM_W'(LEN_MAX)) begin
                    length_next = LEN_MAX;
                end else begin
                    length_next = acc_sum[LEN_BITS-1:0];
                end
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // A point at the origin becomes the head; a later one replaces it.
                if (x_reg == '0 && y_reg == '0) begin
                    head_pos_next = count_reg[HP_W-1:0];
                    head_sum_next = length_reg;
                end
                prev_x_next = x_reg;
                prev_y_next = y_reg;
                count_next  = count_reg + 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {{PAD_W{1'b0}},
                                     count_ext[CNT_BITS-1:0],
                                     head_pos_ext[IDX_BITS-1:0],
                                     head_sum_reg,
                                     length_reg};
                    m_user_next   = dropped_reg;
                    prev_x_next   = '0;
                    prev_y_next   = '0;
                    count_next    = '0;
                    length_next   = '0;
                    head_sum_next = '0;
                    head_pos_next = '0;
                    dropped_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            count_reg    <= '0;
            length_reg   <= '0;
            head_sum_reg <= '0;
            head_pos_reg <= '0;
            dropped_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            count_reg    <= count_next;
            length_reg   <= length_next;
            head_sum_reg <= head_sum_next;
            head_pos_reg <= head_pos_next;
            dropped_reg  <= dropped_next;
            m_valid_reg  <= m_valid_next;
        end
        x_reg      <= x_next;
        y_reg      <= y_next;
        last_reg   <= last_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        prod_reg   <= prod_next;
        sumsq_reg  <= sumsq_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_root_in_root_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (sqrt_sts.busy || sqrt_sts.done) |-> state_reg == ST_ROOT)
        else $error("square root active outside the root state");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("point count beyond capacity");

    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && last_reg && out_free)
            |=> m_valid_reg && count_reg == '0 && !dropped_reg)
        else $error("result issued without clearing the polyline");

    a_head_before_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (CNT_W'(head_pos_reg) < count_reg))
        else $error("head index not below point count");

endmodule

### tb/pla_checker.sv
`timescale 1ns / 100ps

module pla_checker
    import pla_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // Fields from bit 0 up: x_coord, y_coord, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: total_length, head_offset, head_index, point_count, zero fill.
    input  logic [M_TDATA_W-1:0]                m_axis_tdata,
    // Fields: overflowed.
    input  logic                                m_axis_tuser,
    output int                                  mismatch_count,
    output int                                  pending_results
);

    typedef longint unsigned u64_t;

    typedef struct {
        logic [LEN_BITS-1:0] total;
        logic [LEN_BITS-1:0] head_off;
        logic [IDX_BITS-1:0] head_idx;
        logic [CNT_BITS-1:0] count;
        logic                dropped;
    } path_summary_t;

    path_summary_t expected_summaries[$];

    // Shadow of the polyline state.
    logic signed [COORD_BITS-1:0] prev_x, prev_y;
    int   points_held;
    u64_t run_length;
    u64_t head_length;
    int   head_at;
    logic overflow_seen;
    int   error_tally;

    initial begin
        error_tally = 0;
    end

    function automatic void clear_path();
        prev_x        = '0;
        prev_y        = '0;
        points_held   = 0;
        run_length    = 0;
        head_length   = 0;
        head_at       = 0;
        overflow_seen = 1'b0;
    endfunction

    // Floor square root, built one result bit at a time from the top.
    function automatic u64_t floor_root(u64_t v);
        u64_t r;
        u64_t c;
        r = 0;
        for (int b = 18; b >= 0; b--) begin
            c = r | (u64_t'(1) << b);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic void take_point(logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] y,
                                       logic last);
        longint        dx;
        longint        dy;
        u64_t          seg;
        path_summary_t s;
        if (points_held < MAX_POINTS) begin
            if (points_held > 0) begin
                dx  = longint'(x) - longint'(prev_x);
                dy  = longint'(y) - longint'(prev_y);
                seg = floor_root(u64_t'(dx * dx + dy * dy));
                if (seg > u64_t'(LEN_MAX) - run_length) begin
                    run_length = u64_t'(LEN_MAX);
                end else begin
                    run_length += seg;
                end
            end
            if (x == 0 && y == 0) begin
                head_at     = points_held;
                head_length = run_length;
            end
            prev_x = x;
            prev_y = y;
            points_held++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (last) begin
            s.total    = run_length[LEN_BITS-1:0];
            s.head_off = head_length[LEN_BITS-1:0];
            s.head_idx = head_at[IDX_BITS-1:0];
            s.count    = points_held[CNT_BITS-1:0];
            s.dropped  = overflow_seen;
            expected_summaries.insert(expected_summaries.size(), s);
            clear_path();
        end
    endfunction

    task automatic flag_mismatch(string what, u64_t got, u64_t want);
        $display("checker: %s mismatch at %0t ns: got %0d, expected %0d",
                 what, $time, got, want);
        error_tally++;
    endtask

    always @(posedge aclk) begin
        path_summary_t want;
        if (!aresetn) begin
            clear_path();
            expected_summaries.delete();
        end else begin
            // Results are matched before a new point is taken, so a result can
            // never be paired with an expectation made at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_summaries.size() == 0) begin
                    flag_mismatch("unsolicited result, total_length",
                                  m_axis_tdata[LEN_BITS-1:0], 0);
                end else begin
                    want = expected_summaries.pop_front();
                    if (m_axis_tdata[LEN_BITS-1:0] !== want.total)
                        flag_mismatch("total_length", m_axis_tdata[LEN_BITS-1:0],
                                      want.total);
                    if (m_axis_tdata[2*LEN_BITS-1:LEN_BITS] !== want.head_off)
                        flag_mismatch("head_offset", m_axis_tdata[2*LEN_BITS-1:LEN_BITS],
                                      want.head_off);
                    if (m_axis_tdata[2*LEN_BITS+IDX_BITS-1:2*LEN_BITS] !== want.head_idx)
                        flag_mismatch("head_index",
                                      m_axis_tdata[2*LEN_BITS+IDX_BITS-1:2*LEN_BITS],
                                      want.head_idx);
                    if (m_axis_tdata[RES_BITS-1:2*LEN_BITS+IDX_BITS] !== want.count)
                        flag_mismatch("point_count",
                                      m_axis_tdata[RES_BITS-1:2*LEN_BITS+IDX_BITS],
                                      want.count);
                    if (m_axis_tuser !== want.dropped)
                        flag_mismatch("overflowed", m_axis_tuser, want.dropped);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_point(s_axis_tdata[COORD_BITS-1:0],
                           s_axis_tdata[2*COORD_BITS-1:COORD_BITS], s_axis_tlast);
            end
        end
        pending_results <= expected_summaries.size();
        mismatch_count  <= error_tally;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pla_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int S_TDATA_W   = ((2*CB+7)/8)*8;
    // Cycles from the last point of a polyline until its result can show up,
    // with margin; used only for the settling time at the end of the run.
    localparam int SETTLE      = 4 * (CB + 10);
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES = 1500;
    localparam int ITEM_GOAL   = 1450;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // Fields from bit 0 up: x_coord, y_coord, zero fill.
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // Fields from bit 0 up: total_length, head_offset, head_index, point_count, zero fill.
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // Fields: overflowed.
    logic                 m_axis_tuser;

    int mismatch_count;
    int pending_results;

    // Bookkeeping of the sender: points left in the current burst and the
    // number of requests accepted so far.
    int burst_left    = 0;
    int points_sent   = 0;
    int hold_requests = 0;

    polyline_length_accumulator #(
        .MAX_POINTS (MAX_POINTS_DEF),
        .COORD_BITS (CB)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The checker watches both channels on its own, predicts each polyline
    // summary and compares it; the top only sees how many went wrong and how
    // many are still outstanding.
    pla_checker #(
        .MAX_POINTS (MAX_POINTS_DEF),
        .COORD_BITS (CB)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Presents one request and waits for the edge that accepts it. The task is
    // entered right after a rising edge, so tready is read as it stood at the
    // accepting edge, before the block updates it.
    task automatic put_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({y, x});
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        points_sent++;
    endtask

    // Sends one point as part of a burst. When a burst runs out, the sender
    // drops tvalid for a random gap; gaps of zero give stretches where it
    // never idles at all. Gaps up to about one and a half point times land on
    // every step of the block's square-root sequence.
    task automatic emit(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        put_point(x, y, last);
    endtask

    // Stops offering points until every result in flight has come back. The
    // first edge lets the outstanding count catch up with the last request.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // A coordinate that is full range, small around the origin, or one of the
    // extremes of the signed field, zero or all ones.
    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return CB'($urandom);
            1, 2:    return CB'(int'($urandom_range(0, 4000)) - 2000);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return {1'b1, {(CB-1){1'b0}}};
                    1:       return {1'b0, {(CB-1){1'b1}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // One polyline of random points; about one point in eight sits exactly at
    // the origin so that head marking, and its last-one-wins rule, is exercised.
    task automatic send_polyline(int n_points);
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        for (int i = 0; i < n_points; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                x = '0;
                y = '0;
            end else begin
                x = pick_coord();
                y = pick_coord();
            end
            emit(x, y, i == n_points - 1);
        end
    endtask

    // Result side: a stall pattern that changes character after each stretch
    // of random length (always ready, mostly ready, mostly stalled), plus a long
    // hold-off whenever the stimulus asks for one.
    initial begin : receiver
        int stretch_left;
        int stall_mode;
        int holds_served;
        stretch_left = 0;
        stall_mode   = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(100, 500);
                stall_mode   = $urandom_range(0, 2);
            end
            stretch_left--;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin : stimulus
        int n_points;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed polylines. A single point gives no segment, so both lengths
        // are zero; a single point at the origin is its own head at index 0.
        emit(16'sd100, -16'sd200, 1'b1);
        emit('0, '0, 1'b1);
        // Largest possible segment: corner to opposite corner.
        emit({1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}}, 1'b0);
        emit({1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}}, 1'b1);
        // Two origin points; the later one sets head index and offset.
        emit(16'sd5, 16'sd5, 1'b0);
        emit('0, '0, 1'b0);
        emit(16'sd3, 16'sd4, 1'b0);
        emit('0, '0, 1'b0);
        emit(16'h5555, 16'haaaa, 1'b1);
        // Head at the very first point, then a plain 3-4-5 segment.
        emit('0, '0, 1'b0);
        emit(16'sd48, 16'sd64, 1'b1);
        // No origin point at all, with alternating bit patterns.
        emit(16'haaaa, 16'h5555, 1'b0);
        emit(16'h7fff, 16'h8000, 1'b0);
        emit(16'h8000, 16'h7fff, 1'b1);

        // Let everything come back before the capacity tests.
        drain_results();

        // More points than the block holds: the points past capacity are
        // ignored, including a last point at the origin, which must not move
        // the head but still closes the polyline.
        for (int i = 0; i < MAX_POINTS_DEF + 3; i++) begin
            emit(pick_coord(), pick_coord(), 1'b0);
        end
        emit('0, '0, 1'b1);
        // Exactly at capacity: nothing is dropped.
        send_polyline(MAX_POINTS_DEF);

        // Long hold-off on the result side while the sender keeps going, so a
        // finished result backs up and the block stops taking points.
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 8; i++) begin
            send_polyline($urandom_range(1, 3));
        end

        // Random polylines, mostly short, some medium and the odd one that
        // runs past capacity.
        while (points_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 19))
                0:         n_points = $urandom_range(MAX_POINTS_DEF - 2, MAX_POINTS_DEF + 6);
                1, 2, 3:   n_points = $urandom_range(11, 40);
                default:   n_points = $urandom_range(1, 10);
            endcase
            send_polyline(n_points);
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every point at its full
    // square-root time plus the longest sender gap and receiver stalls).
    initial begin : watchdog
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
